/* rtl/ral_pkg.sv */
package ral_pkg;

	// Field and register widths.
	localparam int DATA_W = 16;
	localparam int RES_W = DATA_W + 1;
	localparam int MEAN_W = DATA_W + 1;
	localparam int RSTD_W = 24;
	localparam int LEN_W = 11;
	localparam int EPS_W = 16;
	localparam int IDX_W = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// Statistics arithmetic.
	localparam int PROD_W = 64;
	localparam int QUO_W = 48;
	localparam int ROOT_W = QUO_W / 2;
	localparam int STEP_W = 6;

	localparam int MAX_ROW_DEF = 1024;
	localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(768);
	localparam logic [EPS_W-1:0] EPSILON_RST = EPS_W'(1);
	localparam logic [RSTD_W-1:0] RSTD_MAX = {RSTD_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b1;

	// Request kinds.
	localparam logic KIND_ELEM = 1'b0;
	localparam logic KIND_NORM = 1'b1;

	// Phases of the row statistics sequence.
	localparam logic [2:0] PH_MCQ = 3'd0;
	localparam logic [2:0] PH_MSS = 3'd1;
	localparam logic [2:0] PH_MEC = 3'd2;
	localparam logic [2:0] PH_DIVM = 3'd3;
	localparam logic [2:0] PH_DIVQ = 3'd4;
	localparam logic [2:0] PH_SQRT = 3'd5;

	// Sources of the output register.
	localparam logic [1:0] SRC_ELEM = 2'd0;
	localparam logic [1:0] SRC_ERR = 2'd1;
	localparam logic [1:0] SRC_STATS = 2'd2;
	localparam logic [1:0] SRC_NORM = 2'd3;

	typedef struct packed {
		logic       acc_en;
		logic       ph_load;
		logic       ph_step;
		logic [2:0] phase;
		logic       commit;
		logic       nrm_s1;
		logic       out_load;
		logic [1:0] out_src;
	} ral_cmd_t;

	typedef struct packed {
		logic row_complete;
		logic norm_err;
	} ral_sts_t;

endpackage

/* rtl/ral_ram.sv */
module ral_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/ral_datapath.sv */
module ral_datapath import ral_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ral_cmd_t                 cmd,
	output ral_sts_t                 sts,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] first_addend,
	input  logic signed [DATA_W-1:0] second_addend,
	input  logic signed [DATA_W-1:0] gain,
	input  logic signed [DATA_W-1:0] offset,
	input  logic [IDX_W-1:0]         index,
	output logic signed [RES_W-1:0]  residual_sum,
	output logic                     row_done,
	output logic signed [MEAN_W-1:0] row_mean,
	output logic [RSTD_W-1:0]        row_rstd,
	output logic signed [DATA_W-1:0] normalized_out,
	output logic                     status
);

	localparam int AW = $clog2(MAX_ROW);
	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int SW = RES_W + CW;
	localparam int QW = 2 * RES_W + CW;
	localparam int DIFF_W = RES_W + 1;
	localparam int P1_W = RSTD_W + 1 + DIFF_W;
	localparam int T_W = P1_W - 16;
	localparam int P2_W = T_W + DATA_W;
	localparam int V_W = P2_W - 8 + 1;
	localparam logic signed [V_W-1:0] V_HI = V_W'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [V_W-1:0] V_LO = -V_HI - V_W'(1);

	logic [LEN_W-1:0] row_length_q;
	logic [EPS_W-1:0] eps_q;
	logic [CW-1:0]    len_eff;

	logic [CW-1:0]           count_q;
	logic signed [SW-1:0]    sum_q;
	logic [QW-1:0]           sq_q;
	logic [CW-1:0]           count_nxt;
	logic signed [SW-1:0]    sum_nxt;
	logic [QW-1:0]           sq_nxt;
	logic signed [RES_W-1:0] elem_sum;
	logic signed [2*RES_W-1:0] elem_sq;
	logic                    is_elem;

	logic                     stats_ready_q;
	logic [CW-1:0]            held_len_q;
	logic signed [MEAN_W-1:0] held_mean_q;
	logic [RSTD_W-1:0]        held_rstd_q;

	logic [CW-1:0]            stat_c_q;
	logic signed [SW-1:0]     stat_s_q;
	logic [QW-1:0]            stat_q_q;
	logic signed [RES_W-1:0]  res_q;
	logic [SW-1:0]            abs_s;

	logic [PROD_W-1:0] mc_q;
	logic [SW-1:0]     mp_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] num_q;
	logic [PROD_W-1:0] d_q;
	logic [EPS_W+CW-1:0] epsc;
	logic [2*CW-1:0]   c2;

	logic [CW-1:0] dm_rem_q;
	logic [SW-1:0] dm_quo_q;
	logic [CW:0]   dm_sh;
	logic signed [SW-1:0] mean_full;
	logic signed [MEAN_W-1:0] mean_q;

	logic [PROD_W-1:0] dq_rem_q;
	logic [QUO_W-1:0]  dq_quo_q;
	logic [PROD_W:0]   dq_sh;
	logic              sat_q;

	logic [QUO_W-1:0]    sq_rad_q;
	logic [ROOT_W:0]     sq_rem_q;
	logic [ROOT_W-1:0]   sq_root_q;
	logic [ROOT_W+2:0]   sq_cur;
	logic [ROOT_W+2:0]   sq_trial;
	logic [RSTD_W-1:0]   rstd_new;

	logic                     ram_wr;
	logic                     ram_rd;
	logic [RES_W-1:0]         ram_rd_data;
	logic signed [DATA_W-1:0] g_q;
	logic signed [DATA_W-1:0] o_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [P1_W-1:0]   nrm_p1;
	logic signed [T_W-1:0]    t_s1;
	logic signed [P2_W-1:0]   nrm_p2;
	logic signed [V_W-1:0]    nrm_v;
	logic signed [DATA_W-1:0] nrm_sat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			eps_q <= EPSILON_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data[LEN_W-1:0];
				REG_EPSILON:    eps_q <= cfg_data[EPS_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		if (row_length_q == '0) begin
			len_eff = CW'(1);
		end else if (32'(row_length_q) > 32'(MAX_ROW)) begin
			len_eff = CW'(MAX_ROW);
		end else begin
			len_eff = CW'(row_length_q);
		end
	end

	// Element accumulation.
	assign is_elem = (kind == KIND_ELEM);
	assign elem_sum = RES_W'(first_addend) + RES_W'(second_addend);
	assign elem_sq = elem_sum * elem_sum;
	assign count_nxt = count_q + CW'(1);
	assign sum_nxt = sum_q + SW'(elem_sum);
	assign sq_nxt = sq_q + QW'($unsigned(elem_sq));

	assign sts.row_complete = (count_nxt >= len_eff);
	assign sts.norm_err = !stats_ready_q || (32'(index) >= 32'(held_len_q))
		|| (32'(index) >= 32'(MAX_ROW));

	assign ram_wr = cmd.acc_en && is_elem;
	assign ram_rd = cmd.acc_en && !is_elem;

	ral_ram #(
		.WIDTH(RES_W),
		.DEPTH(MAX_ROW)
	) u_row_buf (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(elem_sum),
		.rd_en  (ram_rd),
		.rd_addr(AW'(index)),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			stats_ready_q <= 1'b0;
			held_len_q <= '0;
			held_mean_q <= '0;
			held_rstd_q <= '0;
		end else begin
			if (ram_wr) begin
				if (sts.row_complete) begin
					count_q <= '0;
					sum_q <= '0;
					sq_q <= '0;
				end else begin
					count_q <= count_nxt;
					sum_q <= sum_nxt;
					sq_q <= sq_nxt;
					stats_ready_q <= 1'b0;
				end
			end
			if (cmd.commit) begin
				stats_ready_q <= 1'b1;
				held_len_q <= stat_c_q;
				held_mean_q <= mean_q;
				held_rstd_q <= rstd_new;
			end
		end
	end

	// Snapshot of a finished row and request payload.
	always_ff @(posedge clk) begin
		if (ram_wr) begin
			res_q <= elem_sum;
			if (sts.row_complete) begin
				stat_c_q <= count_nxt;
				stat_s_q <= sum_nxt;
				stat_q_q <= sq_nxt;
			end
		end
		if (ram_rd) begin
			g_q <= gain;
			o_q <= offset;
		end
	end

	// Row statistics: shift-add multiplier, two restoring dividers and a root.
	assign abs_s = stat_s_q[SW-1] ? SW'(-stat_s_q) : SW'(stat_s_q);
	assign epsc = eps_q * stat_c_q;
	assign c2 = stat_c_q * stat_c_q;
	assign dm_sh = {dm_rem_q, dm_quo_q[SW-1]};
	assign dq_sh = {dq_rem_q, 1'b0};
	assign mean_full = stat_s_q[SW-1] ? -$signed(dm_quo_q) : $signed(dm_quo_q);
	assign sq_cur = {sq_rem_q, sq_rad_q[QUO_W-1 -: 2]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign rstd_new = sat_q ? RSTD_MAX : RSTD_W'(sq_root_q);

	always_ff @(posedge clk) begin
		if (cmd.ph_load) begin
			unique case (cmd.phase)
				PH_MCQ: begin
					mc_q <= PROD_W'(stat_q_q);
					mp_q <= SW'(stat_c_q);
					prod_q <= '0;
				end
				PH_MSS: begin
					num_q <= prod_q;
					mc_q <= PROD_W'(abs_s);
					mp_q <= abs_s;
					prod_q <= '0;
				end
				PH_MEC: begin
					num_q <= num_q - prod_q;
					mc_q <= PROD_W'(epsc);
					mp_q <= SW'(stat_c_q);
					prod_q <= '0;
				end
				PH_DIVM: begin
					d_q <= num_q + prod_q;
					dm_rem_q <= '0;
					dm_quo_q <= abs_s;
				end
				PH_DIVQ: begin
					mean_q <= mean_full[MEAN_W-1:0];
					sat_q <= (d_q <= PROD_W'(c2));
					dq_rem_q <= PROD_W'(c2);
					dq_quo_q <= '0;
				end
				PH_SQRT: begin
					sq_rad_q <= dq_quo_q;
					sq_rem_q <= '0;
					sq_root_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.ph_step) begin
			unique case (cmd.phase)
				PH_MCQ, PH_MSS, PH_MEC: begin
					if (mp_q[0]) begin
						prod_q <= prod_q + mc_q;
					end
					mc_q <= {mc_q[PROD_W-2:0], 1'b0};
					mp_q <= {1'b0, mp_q[SW-1:1]};
				end
				PH_DIVM: begin
					if (dm_sh >= {1'b0, stat_c_q}) begin
						dm_rem_q <= CW'(dm_sh - {1'b0, stat_c_q});
						dm_quo_q <= {dm_quo_q[SW-2:0], 1'b1};
					end else begin
						dm_rem_q <= dm_sh[CW-1:0];
						dm_quo_q <= {dm_quo_q[SW-2:0], 1'b0};
					end
				end
				PH_DIVQ: begin
					if (dq_sh >= {1'b0, d_q}) begin
						dq_rem_q <= PROD_W'(dq_sh - {1'b0, d_q});
						dq_quo_q <= {dq_quo_q[QUO_W-2:0], 1'b1};
					end else begin
						dq_rem_q <= dq_sh[PROD_W-1:0];
						dq_quo_q <= {dq_quo_q[QUO_W-2:0], 1'b0};
					end
				end
				PH_SQRT: begin
					if (sq_cur >= sq_trial) begin
						sq_rem_q <= (ROOT_W + 1)'(sq_cur - sq_trial);
						sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b1};
					end else begin
						sq_rem_q <= sq_cur[ROOT_W:0];
						sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b0};
					end
					sq_rad_q <= {sq_rad_q[QUO_W-3:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	// Normalize: scale by rstd, then gain and offset, saturated.
	assign diff = DIFF_W'($signed(ram_rd_data)) - DIFF_W'(held_mean_q);
	assign nrm_p1 = $signed({1'b0, held_rstd_q}) * diff;
	assign nrm_p2 = t_s1 * g_q;
	assign nrm_v = V_W'($signed(nrm_p2[P2_W-1:8])) + V_W'(o_q);

	always_comb begin
		if (nrm_v > V_HI) begin
			nrm_sat = V_HI[DATA_W-1:0];
		end else if (nrm_v < V_LO) begin
			nrm_sat = V_LO[DATA_W-1:0];
		end else begin
			nrm_sat = nrm_v[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nrm_s1) begin
			t_s1 <= nrm_p1[P1_W-1:16];
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_src)
				SRC_ELEM: begin
					residual_sum <= elem_sum;
					row_done <= 1'b0;
					row_mean <= '0;
					row_rstd <= '0;
					normalized_out <= '0;
					status <= 1'b0;
				end
				SRC_ERR: begin
					residual_sum <= '0;
					row_done <= 1'b0;
					row_mean <= '0;
					row_rstd <= '0;
					normalized_out <= '0;
					status <= 1'b1;
				end
				SRC_STATS: begin
					residual_sum <= res_q;
					row_done <= 1'b1;
					row_mean <= mean_q;
					row_rstd <= rstd_new;
					normalized_out <= '0;
					status <= 1'b0;
				end
				SRC_NORM: begin
					residual_sum <= '0;
					row_done <= 1'b0;
					row_mean <= '0;
					row_rstd <= '0;
					normalized_out <= nrm_sat;
					status <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ral_ctrl.sv */
module ral_ctrl import ral_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     kind,
	output logic     out_valid,
	input  logic     out_stall,
	input  ral_sts_t sts,
	output ral_cmd_t cmd
);

	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int SW = RES_W + CW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_NRM1 = 3'd4;
	localparam logic [2:0] ST_NRM2 = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [2:0]        phase_q;
	logic [2:0]        phase_d;
	logic [STEP_W-1:0] cnt_q;
	logic [STEP_W-1:0] cnt_d;
	logic [STEP_W-1:0] steps;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		unique case (phase_q)
			PH_DIVQ: steps = STEP_W'(QUO_W);
			PH_SQRT: steps = STEP_W'(ROOT_W);
			default: steps = STEP_W'(SW);
		endcase
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.phase = phase_q;
		cmd.acc_en = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_ELEM) begin
						if (sts.row_complete) begin
							phase_d = PH_MCQ;
							state_d = ST_LOAD;
						end else begin
							cmd.out_load = 1'b1;
							cmd.out_src = SRC_ELEM;
						end
					end else if (sts.norm_err) begin
						cmd.out_load = 1'b1;
						cmd.out_src = SRC_ERR;
					end else begin
						state_d = ST_NRM1;
					end
				end
			end
			ST_LOAD: begin
				cmd.ph_load = 1'b1;
				cnt_d = steps - STEP_W'(1);
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.ph_step = 1'b1;
				cnt_d = cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					if (phase_q == PH_SQRT) begin
						state_d = ST_DONE;
					end else begin
						phase_d = phase_q + 3'd1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_src = SRC_STATS;
					state_d = ST_IDLE;
				end
			end
			ST_NRM1: begin
				cmd.nrm_s1 = 1'b1;
				state_d = ST_NRM2;
			end
			ST_NRM2: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src = SRC_NORM;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MCQ;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/residual_add_layernorm.sv */
// Fused residual add and layer normalization over one row of channels.
// The input channel carries one request per handshake (in_valid, in_stall):
// an element request adds its two Q8.8 addends, and a normalize request asks
// for the normalized value of one buffered channel. Every request gives
// exactly one result on the output channel (out_valid, out_stall).
// An element request that does not finish a row is answered in the cycle after
// acceptance, and such requests can be accepted on every cycle while the
// output register drains. The element that finishes a row starts the
// statistics sequence: four shift-add multiply or divide passes of
// 17 + clog2(MAX_ROW + 1) steps each, a 48-step divide and a 24-step square
// root. A normalize request passes, in order, through the row buffer read,
// the rstd multiply and the gain multiply. An index outside the finished row,
// or no finished row, is answered with status set and skips those steps.
// While a request is in work, or the output register is full and stalled,
// in_stall is high. Reset clears the statistics, the element count and the
// output valid; the row buffer keeps its contents, and only entries of the
// finished row are ever used in a result.
// Configuration writes are taken at any cycle and belong in idle periods.
module residual_add_layernorm import ral_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] first_addend,
	input  logic signed [DATA_W-1:0] second_addend,
	input  logic signed [DATA_W-1:0] gain,
	input  logic signed [DATA_W-1:0] offset,
	input  logic [IDX_W-1:0]         index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RES_W-1:0]  residual_sum,
	output logic                     row_done,
	output logic signed [MEAN_W-1:0] row_mean,
	output logic [RSTD_W-1:0]        row_rstd,
	output logic signed [DATA_W-1:0] normalized_out,
	output logic                     status
);

	ral_cmd_t cmd;
	ral_sts_t sts;

	// The controller sequences requests and the statistics phases.
	ral_ctrl #(
		.MAX_ROW(MAX_ROW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the row buffer, accumulators and arithmetic units.
	ral_datapath #(
		.MAX_ROW(MAX_ROW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.first_addend  (first_addend),
		.second_addend (second_addend),
		.gain          (gain),
		.offset        (offset),
		.index         (index),
		.residual_sum  (residual_sum),
		.row_done      (row_done),
		.row_mean      (row_mean),
		.row_rstd      (row_rstd),
		.normalized_out(normalized_out),
		.status        (status)
	);

endmodule
